@@ src/rps_pkg.sv @@
`default_nettype none
package rps_pkg;

    localparam int FILE_W  = 16;
    localparam int SLOT_W  = 17;
    localparam int CRIT_W  = 9;
    localparam int BLK_W   = 16;
    localparam int CNT_W   = 17;
    localparam int Q_W     = 17;
    localparam int CC_W    = 13;
    localparam int PROD_W  = 33;
    localparam int MUL_W   = 17;
    localparam int STEP_W  = 6;
    localparam int STAT_W  = 2;
    localparam int KIND_W  = 2;
    localparam int STATE_W = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SLICE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CRIT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CREATOR = 2'd2;

    localparam logic CMD_NEXT   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] REG_TOTAL = 2'd0;
    localparam logic [1:0] REG_MAXB  = 2'd1;
    localparam logic [1:0] REG_CRIT  = 2'd2;

    typedef logic [STATE_W-1:0] state_t;

    // number of bits needed to hold v
    function automatic logic [4:0] bit_len(input logic [16:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (v[i])
                n = 5'(i + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ src/recovery_packet_schedule.sv @@
`default_nettype none
// Recovery packet scheduler. A write to any of the three registers restarts
// the cursor and rederives the file plan, which holds s_axis_tready low
// while the plan is derived (with a pass through the divider unless
// max_blocks_per_file is zero). Each request (tuser 0: next packet at the
// cursor, tuser 1: look up file/slot) gives exactly one result. A request
// holds the block until its result is formed: shortest when the cursor is
// exhausted, then a file out of range, then a creator, first slot or slot
// out of range, longest for a critical packet. The time is set by one
// bit-serial multiplier and one bit-serial restoring divider, shared by up
// to three products and three quotients per slot. A new request is taken
// while the previous result still waits in the output register.
module recovery_packet_schedule
    import rps_pkg::*;
#(
    parameter int BLOCK_COUNT_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [15:0]           cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // file_number[15:0], slot_index[32:16]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_file[15:0], out_index[32:16], recovery_block[48:33], critical_index[57:49]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // status[1:0], packet_kind[3:2]
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    // last_in_file
    output logic                       m_axis_tlast
);

    localparam int N  = BLOCK_COUNT_BITS;
    localparam int EW = $clog2(N + 1);

    localparam state_t S_IDLE = 4'd0;
    localparam state_t S_DRVS = 4'd1;
    localparam state_t S_DRV  = 4'd2;
    localparam state_t S_LOC  = 4'd4;
    localparam state_t S_MULS = 4'd5;
    localparam state_t S_GEOM = 4'd6;
    localparam state_t S_CHK  = 4'd7;
    localparam state_t S_MUL1 = 4'd8;
    localparam state_t S_DIV1 = 4'd9;
    localparam state_t S_MUL2 = 4'd10;
    localparam state_t S_DIV2 = 4'd11;
    localparam state_t S_DIV3 = 4'd12;
    localparam state_t S_OUT  = 4'd13;

    state_t              state_reg, state_next;
    logic [N-1:0]        total_reg, total_next;
    logic [N-1:0]        maxb_reg, maxb_next;
    logic [CRIT_W-1:0]   crit_reg, crit_next;
    logic [N-1:0]        whole_reg, whole_next;
    logic [N-1:0]        extra_reg, extra_next;
    logic [EW-1:0]       exp_reg, exp_next;
    logic [CNT_W-1:0]    fcnt_reg, fcnt_next;
    logic [FILE_W-1:0]   cur_file_reg, cur_file_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic                cmd_reg, cmd_next;
    logic [FILE_W-1:0]   f_reg, f_next;
    logic [SLOT_W-1:0]   p_reg, p_next;
    logic [BLK_W-1:0]    s_reg, s_next;
    logic [N-1:0]        b_reg, b_next;
    logic [CC_W-1:0]     cc_reg, cc_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [PROD_W-1:0]   mul_acc_reg, mul_acc_next;
    logic [PROD_W-1:0]   mul_a_reg, mul_a_next;
    logic [MUL_W-1:0]    mul_b_reg, mul_b_next;
    logic [Q_W-1:0]      div_rem_reg, div_rem_next;
    logic [PROD_W-1:0]   div_quo_reg, div_quo_next;
    logic [Q_W-1:0]      d_reg, d_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;
    logic [BLK_W-1:0]    res_blk_reg, res_blk_next;
    logic [CRIT_W-1:0]   res_crit_reg, res_crit_next;
    logic                res_last_reg, res_last_next;
    logic                ov_reg, ov_next;
    logic [STAT_W-1:0]   o_stat_reg, o_stat_next;
    logic [KIND_W-1:0]   o_kind_reg, o_kind_next;
    logic [FILE_W-1:0]   o_file_reg, o_file_next;
    logic [SLOT_W-1:0]   o_idx_reg, o_idx_next;
    logic [BLK_W-1:0]    o_blk_reg, o_blk_next;
    logic [CRIT_W-1:0]   o_crit_reg, o_crit_next;
    logic                o_last_reg, o_last_next;

    // shared serial units
    logic [PROD_W-1:0]   mul_sum;
    logic                mul_last;
    logic [Q_W:0]        rem_sh;
    logic                div_ge;
    logic [Q_W-1:0]      rem_new;
    logic [PROD_W-1:0]   quo_new;
    logic                div_last;

    // plan and slot geometry
    logic [N-1:0]        drv_whole, drv_extra;
    logic [EW-1:0]       drv_exp;
    logic [N-1:0]        pow_f, s_exp, b_exp;
    logic                f_last_exp;
    logic [4:0]          copies;
    logic [13:0]         cc_full;
    logic                slice_hit;

    assign mul_sum  = mul_b_reg[0] ? mul_acc_reg + mul_a_reg : mul_acc_reg;
    assign mul_last = (cnt_reg == STEP_W'(MUL_W - 1));
    assign rem_sh   = {div_rem_reg, div_quo_reg[PROD_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, d_reg});
    assign rem_new  = div_ge ? Q_W'(rem_sh - {1'b0, d_reg}) : rem_sh[Q_W-1:0];
    assign quo_new  = {div_quo_reg[PROD_W-2:0], div_ge};
    assign div_last = (cnt_reg == STEP_W'(PROD_W - 1));

    always_comb
    begin
        if (maxb_reg == '0)
        begin
            drv_whole = '0;
            drv_extra = total_reg;
        end
        else if (quo_new[N-1:0] != '0)
        begin
            drv_whole = quo_new[N-1:0] - N'(1);
            drv_extra = N'({1'b0, rem_new[N-1:0]} + {1'b0, maxb_reg});
        end
        else
        begin
            drv_whole = '0;
            drv_extra = total_reg;
        end
        drv_exp = EW'(bit_len(17'(drv_extra)));
    end

    assign pow_f      = N'(1) << f_reg[3:0];
    assign s_exp      = pow_f - N'(1);
    assign f_last_exp = ((17'(f_reg) + 17'd1) == 17'(exp_reg));
    assign b_exp      = f_last_exp ? extra_reg - s_exp : pow_f;
    assign copies     = bit_len(17'(b_reg));
    assign cc_full    = 14'(copies) * 14'(crit_reg);
    // next > cur exactly when the remainder plus b reaches q
    assign slice_hit  = (({1'b0, rem_new} + {1'b0, Q_W'(b_reg)}) >= {1'b0, q_reg});

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        maxb_next     = maxb_reg;
        crit_next     = crit_reg;
        whole_next    = whole_reg;
        extra_next    = extra_reg;
        exp_next      = exp_reg;
        fcnt_next     = fcnt_reg;
        cur_file_next = cur_file_reg;
        cur_slot_next = cur_slot_reg;
        cmd_next      = cmd_reg;
        f_next        = f_reg;
        p_next        = p_reg;
        s_next        = s_reg;
        b_next        = b_reg;
        cc_next       = cc_reg;
        q_next        = q_reg;
        mul_acc_next  = mul_acc_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        d_next        = d_reg;
        cnt_next      = cnt_reg;
        res_stat_next = res_stat_reg;
        res_kind_next = res_kind_reg;
        res_blk_next  = res_blk_reg;
        res_crit_next = res_crit_reg;
        res_last_next = res_last_reg;
        ov_next       = ov_reg && !m_axis_tready;
        o_stat_next   = o_stat_reg;
        o_kind_next   = o_kind_reg;
        o_file_next   = o_file_reg;
        o_idx_next    = o_idx_reg;
        o_blk_next    = o_blk_reg;
        o_crit_next   = o_crit_reg;
        o_last_next   = o_last_reg;

        // unit stepping, overridden by the transitions below
        if (state_reg == S_MULS || state_reg == S_MUL1 || state_reg == S_MUL2)
        begin
            mul_acc_next = mul_sum;
            mul_a_next   = mul_a_reg << 1;
            mul_b_next   = mul_b_reg >> 1;
            cnt_next     = cnt_reg + STEP_W'(1);
        end
        if (state_reg == S_DRV || state_reg == S_DIV1 || state_reg == S_DIV2
            || state_reg == S_DIV3)
        begin
            div_rem_next = rem_new;
            div_quo_next = quo_new;
            cnt_next     = cnt_reg + STEP_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next      = s_axis_tuser;
                    res_kind_next = KIND_SLICE;
                    res_blk_next  = '0;
                    res_crit_next = '0;
                    res_last_next = 1'b0;
                    if (s_axis_tuser == CMD_LOOKUP)
                    begin
                        f_next     = s_axis_tdata[15:0];
                        p_next     = s_axis_tdata[32:16];
                        state_next = S_LOC;
                    end
                    else if (17'(cur_file_reg) >= fcnt_reg)
                    begin
                        res_stat_next = ST_DONE;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        f_next     = cur_file_reg;
                        p_next     = cur_slot_reg;
                        state_next = S_LOC;
                    end
                end
            end
            S_DRVS:
            begin
                if (maxb_reg == '0)
                begin
                    whole_next = drv_whole;
                    extra_next = drv_extra;
                    exp_next   = drv_exp;
                    fcnt_next  = CNT_W'(drv_whole) + CNT_W'(drv_exp);
                    state_next = S_IDLE;
                end
                else
                begin
                    div_quo_next = PROD_W'(total_reg);
                    div_rem_next = '0;
                    d_next       = Q_W'(maxb_reg);
                    cnt_next     = '0;
                    state_next   = S_DRV;
                end
            end
            S_DRV:
            begin
                if (div_last)
                begin
                    whole_next = drv_whole;
                    extra_next = drv_extra;
                    exp_next   = drv_exp;
                    fcnt_next  = CNT_W'(drv_whole) + CNT_W'(drv_exp);
                    state_next = S_IDLE;
                end
            end
            S_LOC:
            begin
                if (17'(f_reg) >= fcnt_reg)
                begin
                    res_stat_next = ST_NONE;
                    state_next    = S_OUT;
                end
                else if (17'(f_reg) < 17'(exp_reg))
                begin
                    s_next     = BLK_W'(s_exp);
                    b_next     = b_exp;
                    state_next = S_GEOM;
                end
                else
                begin
                    b_next       = maxb_reg;
                    mul_acc_next = '0;
                    mul_a_next   = PROD_W'(f_reg - FILE_W'(exp_reg));
                    mul_b_next   = MUL_W'(maxb_reg);
                    cnt_next     = '0;
                    state_next   = S_MULS;
                end
            end
            S_MULS:
            begin
                if (mul_last)
                begin
                    s_next     = BLK_W'(mul_sum) + BLK_W'(extra_reg);
                    state_next = S_GEOM;
                end
            end
            S_GEOM:
            begin
                cc_next    = cc_full[CC_W-1:0];
                q_next     = Q_W'(b_reg) + Q_W'(cc_full[CC_W-1:0]);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                res_stat_next = ST_OK;
                if (p_reg > q_reg)
                begin
                    res_stat_next = ST_NONE;
                    state_next    = S_OUT;
                end
                else if (p_reg == q_reg)
                begin
                    res_kind_next = KIND_CREATOR;
                    res_last_next = 1'b1;
                    state_next    = S_OUT;
                end
                else if (p_reg == '0)
                begin
                    res_kind_next = KIND_SLICE;
                    res_blk_next  = s_reg;
                    state_next    = S_OUT;
                end
                else
                begin
                    mul_acc_next = '0;
                    mul_a_next   = PROD_W'(p_reg);
                    mul_b_next   = MUL_W'(b_reg);
                    cnt_next     = '0;
                    state_next   = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (mul_last)
                begin
                    div_quo_next = mul_sum - PROD_W'(1);
                    div_rem_next = '0;
                    d_next       = q_reg;
                    cnt_next     = '0;
                    state_next   = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_last)
                begin
                    if (slice_hit)
                    begin
                        res_kind_next = KIND_SLICE;
                        res_blk_next  = s_reg + BLK_W'(quo_new) + BLK_W'(1);
                        state_next    = S_OUT;
                    end
                    else if (crit_reg == '0)
                    begin
                        res_kind_next = KIND_CRIT;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        res_kind_next = KIND_CRIT;
                        mul_acc_next  = '0;
                        mul_a_next    = PROD_W'(p_reg);
                        mul_b_next    = MUL_W'(cc_reg);
                        cnt_next      = '0;
                        state_next    = S_MUL2;
                    end
                end
            end
            S_MUL2:
            begin
                if (mul_last)
                begin
                    div_quo_next = mul_sum - PROD_W'(1);
                    div_rem_next = '0;
                    d_next       = q_reg;
                    cnt_next     = '0;
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_last)
                begin
                    div_quo_next = quo_new;
                    div_rem_next = '0;
                    d_next       = Q_W'(crit_reg);
                    cnt_next     = '0;
                    state_next   = S_DIV3;
                end
            end
            S_DIV3:
            begin
                if (div_last)
                begin
                    res_crit_next = rem_new[CRIT_W-1:0];
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next     = 1'b1;
                    o_stat_next = res_stat_reg;
                    o_kind_next = res_kind_reg;
                    o_blk_next  = res_blk_reg;
                    o_crit_next = res_crit_reg;
                    o_last_next = res_last_reg;
                    o_file_next = (res_stat_reg == ST_OK) ? f_reg : '0;
                    o_idx_next  = (res_stat_reg == ST_OK) ? p_reg : '0;
                    if (cmd_reg == CMD_NEXT && res_stat_reg == ST_OK)
                    begin
                        if (res_last_reg)
                        begin
                            cur_file_next = cur_file_reg + FILE_W'(1);
                            cur_slot_next = '0;
                        end
                        else
                        begin
                            cur_slot_next = cur_slot_reg + SLOT_W'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we && cfg_addr <= REG_CRIT)
        begin
            case (cfg_addr)
                REG_TOTAL: total_next = cfg_wdata[N-1:0];
                REG_MAXB:  maxb_next  = cfg_wdata[N-1:0];
                default:   crit_next  = cfg_wdata[CRIT_W-1:0];
            endcase
            cur_file_next = '0;
            cur_slot_next = '0;
            state_next    = S_DRVS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            maxb_reg     <= N'(1);
            crit_reg     <= CRIT_W'(3);
            whole_reg    <= '0;
            extra_reg    <= '0;
            exp_reg      <= '0;
            fcnt_reg     <= '0;
            cur_file_reg <= '0;
            cur_slot_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            maxb_reg     <= maxb_next;
            crit_reg     <= crit_next;
            whole_reg    <= whole_next;
            extra_reg    <= extra_next;
            exp_reg      <= exp_next;
            fcnt_reg     <= fcnt_next;
            cur_file_reg <= cur_file_next;
            cur_slot_reg <= cur_slot_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        f_reg        <= f_next;
        p_reg        <= p_next;
        s_reg        <= s_next;
        b_reg        <= b_next;
        cc_reg       <= cc_next;
        q_reg        <= q_next;
        mul_acc_reg  <= mul_acc_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        d_reg        <= d_next;
        cnt_reg      <= cnt_next;
        res_stat_reg <= res_stat_next;
        res_kind_reg <= res_kind_next;
        res_blk_reg  <= res_blk_next;
        res_crit_reg <= res_crit_next;
        res_last_reg <= res_last_next;
        o_stat_reg   <= o_stat_next;
        o_kind_reg   <= o_kind_next;
        o_file_reg   <= o_file_next;
        o_idx_reg    <= o_idx_next;
        o_blk_reg    <= o_blk_next;
        o_crit_reg   <= o_crit_next;
        o_last_reg   <= o_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, o_crit_reg, o_blk_reg, o_idx_reg, o_file_reg};
    assign m_axis_tuser  = {o_kind_reg, o_stat_reg};
    assign m_axis_tlast  = o_last_reg;

    // whole-file count stays a part of the file count
    logic unused_ok;
    assign unused_ok = (fcnt_reg >= CNT_W'(whole_reg));

    a_plan_order: assert property (@(posedge clk) disable iff (!rst_n)
        unused_ok && fcnt_reg >= CNT_W'(exp_reg))
        else $error("file count below its parts");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && o_stat_reg != ST_OK |->
            o_file_reg == '0 && o_idx_reg == '0 && o_blk_reg == '0
            && o_crit_reg == '0 && !o_last_reg && o_kind_reg == KIND_SLICE)
        else $error("fields set on a result without a packet");

    a_creator_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (o_kind_reg == KIND_CREATOR) == o_last_reg)
        else $error("creator and last flag disagree");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_addr <= REG_CRIT |=>
            cur_file_reg == '0 && cur_slot_reg == '0 && state_reg == S_DRVS)
        else $error("register write did not restart the cursor");

    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && o_kind_reg != KIND_SLICE |-> o_blk_reg == '0)
        else $error("block number on a non-slice packet");

endmodule
`default_nettype wire
